### design/cdts_pkg.sv
// Shared types, constants and calendar helpers for the date/time stepper.
`timescale 1ns / 1ps

package cdts_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int MILLIS_W = 16;
    localparam int STEP_W   = 32;
    localparam int KIND_W   = 2;

    // Working widths: accumulator holds the signed millisecond total,
    // the date keeps a signed year that may leave 0..16383 by one.
    localparam int ACC_W   = 34;
    localparam int YEAR_SW = 16;
    localparam int R400_W  = 9;
    localparam int PROD_W  = 27;
    localparam int BIT_W   = 3;

    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [YEAR_SW-1:0] t_year;
    typedef logic [R400_W-1:0]         t_r400;

    // Calendar codes
    localparam logic [KIND_W-1:0] CAL_GREG   = 2'd0;
    localparam logic [KIND_W-1:0] CAL_FIXED  = 2'd1;
    localparam logic [KIND_W-1:0] CAL_THIRTY = 2'd2;

    // Month numbers used by the rollover logic
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_LEAP_FEB = 5'd29;
    localparam logic [DAY_W-1:0] DAY_THIRTY   = 5'd30;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Millisecond constants
    localparam t_acc MS_PER_DAY    = t_acc'(86400000);
    localparam t_acc MS_PER_HOUR   = t_acc'(3600000);
    localparam t_acc MS_PER_MINUTE = t_acc'(60000);
    localparam logic [PROD_W-1:0] MS_HOUR_U   = PROD_W'(3600000);
    localparam logic [PROD_W-1:0] MS_MINUTE_U = PROD_W'(60000);

    // Leap cycle
    localparam t_acc  CYCLE_YEARS = t_acc'(400);
    localparam t_r400 CYCLE_LAST  = R400_W'(399);
    localparam t_r400 CENT_1      = R400_W'(100);
    localparam t_r400 CENT_2      = R400_W'(200);
    localparam t_r400 CENT_3      = R400_W'(300);
    localparam t_year YEAR_MAX    = t_year'(9999);

    // Shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // Controls from the sequencer to the date unit
    typedef struct packed {
        logic load;      // take the starting date
        logic set_r400;  // take the year position in the 400-year cycle
        logic move;      // move the date one day
        logic back;      // direction of the move: back when set
    } t_date_ctl;

    // Length of a month (1..12) under the given calendar, leap day excluded
    function automatic logic [DAY_W-1:0] days_in(input logic [KIND_W-1:0] kind,
                                                 input logic [MONTH_W-1:0] month);
        logic [MONTH_W-1:0] idx;
        idx = month - MONTH_JAN;
        if (kind == CAL_THIRTY) begin
            return DAY_THIRTY;
        end else if (month < MONTH_JAN || month > MONTH_DEC) begin
            return MONTH_LEN[0];
        end else begin
            return MONTH_LEN[idx];
        end
    endfunction

endpackage

### design/cdts_in_if.sv
// Request channel of the date/time stepper.
`timescale 1ns / 1ps

interface cdts_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [cdts_pkg::YEAR_W-1:0]           year_in;
    logic [cdts_pkg::MONTH_W-1:0]          month_in;
    logic [cdts_pkg::DAY_W-1:0]            day_in;
    logic [cdts_pkg::HOUR_W-1:0]           hour_in;
    logic [cdts_pkg::MINUTE_W-1:0]         minute_in;
    logic [cdts_pkg::MILLIS_W-1:0]         millis_in;
    logic signed [cdts_pkg::STEP_W-1:0]    step_millis;

    modport source (
        output valid, year_in, month_in, day_in, hour_in, minute_in, millis_in,
               step_millis,
        input  ready
    );

    modport sink (
        input  valid, year_in, month_in, day_in, hour_in, minute_in, millis_in,
               step_millis,
        output ready
    );
endinterface

### design/cdts_out_if.sv
// Result channel of the date/time stepper.
`timescale 1ns / 1ps

interface cdts_out_if;
    logic                          valid;
    logic                          ready;
    logic [cdts_pkg::YEAR_W-1:0]   year_out;
    logic [cdts_pkg::MONTH_W-1:0]  month_out;
    logic [cdts_pkg::DAY_W-1:0]    day_out;
    logic [cdts_pkg::HOUR_W-1:0]   hour_out;
    logic [cdts_pkg::MINUTE_W-1:0] minute_out;
    logic [cdts_pkg::MILLIS_W-1:0] millis_out;
    logic                          year_overflow;

    modport source (
        output valid, year_out, month_out, day_out, hour_out, minute_out, millis_out,
               year_overflow,
        input  ready
    );

    modport sink (
        input  valid, year_out, month_out, day_out, hour_out, minute_out, millis_out,
               year_overflow,
        output ready
    );
endinterface

### design/cdts_alu.sv
// Shared 34-bit add/subtract unit of the date/time stepper.
`timescale 1ns / 1ps

module cdts_alu (
    input  cdts_pkg::t_acc    i_a,
    input  cdts_pkg::t_acc    i_b,
    input  cdts_pkg::t_alu_op i_op,
    output cdts_pkg::t_acc    o_res,
    output logic              o_neg
);

    always_comb begin
        if (i_op == cdts_pkg::ALU_SUB) begin
            o_res = i_a - i_b;
        end else begin
            o_res = i_a + i_b;
        end
        o_neg = o_res[cdts_pkg::ACC_W-1];
    end

endmodule

### design/cdts_date.sv
// Date register with one-day forward/back rollover and leap tracking.
`timescale 1ns / 1ps

module cdts_date (
    input  logic                                i_clk,
    input  cdts_pkg::t_date_ctl                 i_ctl,
    input  logic [cdts_pkg::KIND_W-1:0]         i_kind,
    input  logic [cdts_pkg::YEAR_W-1:0]         i_year,
    input  logic [cdts_pkg::MONTH_W-1:0]        i_month,
    input  logic [cdts_pkg::DAY_W-1:0]          i_day,
    input  cdts_pkg::t_r400                     i_r400,
    output cdts_pkg::t_year                     o_year,
    output logic [cdts_pkg::MONTH_W-1:0]        o_month,
    output logic [cdts_pkg::DAY_W-1:0]          o_day
);

    cdts_pkg::t_year                 r_year, n_year;
    logic [cdts_pkg::MONTH_W-1:0]    r_month, n_month;
    logic [cdts_pkg::DAY_W-1:0]      r_day;
    cdts_pkg::t_r400                 r_r400, n_r400;
    logic signed [cdts_pkg::DAY_W+1:0] n_day;

    logic                            w_leap;
    logic [cdts_pkg::MONTH_W-1:0]    w_month_c;
    logic [cdts_pkg::DAY_W-1:0]      w_dim;

    // Leap year from the position in the 400-year cycle
    assign w_leap = (i_kind == cdts_pkg::CAL_GREG) &&
                    ((r_r400 == '0) ||
                     (r_r400[1:0] == 2'b00 && r_r400 != cdts_pkg::CENT_1 &&
                      r_r400 != cdts_pkg::CENT_2 && r_r400 != cdts_pkg::CENT_3));

    always_comb begin
        // Clamp month into 1..12 before the move
        if (r_month < cdts_pkg::MONTH_JAN) begin
            w_month_c = cdts_pkg::MONTH_JAN;
        end else if (r_month > cdts_pkg::MONTH_DEC) begin
            w_month_c = cdts_pkg::MONTH_DEC;
        end else begin
            w_month_c = r_month;
        end

        n_year  = r_year;
        n_r400  = r_r400;
        n_month = w_month_c;
        w_dim   = '0;
        if (i_ctl.back) begin
            n_day = $signed({2'b00, r_day}) - 7'sd1;
        end else begin
            n_day = $signed({2'b00, r_day}) + 7'sd1;
        end

        // Underflow: last day of the previous month
        if (n_day <= 7'sd0) begin
            if (w_month_c == cdts_pkg::MONTH_JAN) begin
                n_month = cdts_pkg::MONTH_DEC;
                n_year  = r_year - 16'sd1;
                n_r400  = (r_r400 == '0) ? cdts_pkg::CYCLE_LAST : r_r400 - 9'd1;
            end else begin
                n_month = w_month_c - 4'd1;
            end
            w_dim = cdts_pkg::days_in(i_kind, n_month);
            if (n_month == cdts_pkg::MONTH_FEB && w_leap) begin
                n_day = $signed({2'b00, cdts_pkg::DAY_LEAP_FEB});
            end else begin
                n_day = $signed({2'b00, w_dim});
            end
        end

        // Overflow past month end: first day of the next month
        if (!(n_day == $signed({2'b00, cdts_pkg::DAY_LEAP_FEB}) &&
              n_month == cdts_pkg::MONTH_FEB && w_leap)) begin
            w_dim = cdts_pkg::days_in(i_kind, n_month);
            if (n_day > $signed({2'b00, w_dim})) begin
                n_day = 7'sd1;
                if (n_month == cdts_pkg::MONTH_DEC) begin
                    n_month = cdts_pkg::MONTH_JAN;
                    n_year  = r_year + 16'sd1;
                    n_r400  = (r_r400 == cdts_pkg::CYCLE_LAST) ? '0 : r_r400 + 9'd1;
                end else begin
                    n_month = n_month + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_year  <= $signed({2'b00, i_year});
            r_month <= i_month;
            r_day   <= i_day;
        end else if (i_ctl.set_r400) begin
            r_r400 <= i_r400;
        end else if (i_ctl.move) begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day[cdts_pkg::DAY_W-1:0];
            r_r400  <= n_r400;
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

endmodule

### design/calendar_date_time_step.sv
// Top level of the calendar date/time stepper: sequencer, operand select, result register.
`timescale 1ns / 1ps

// Adds a signed millisecond step to a date and time of day and returns the
// rolled-over date and time. One request is taken at a time: i_req.ready is
// high only while the sequencer is idle. The sequencer places the year in the
// 400-year leap cycle, loads the step, adds hours, minutes and milliseconds,
// moves the date one day for each whole day the sum crosses (0 to 26 for the
// full step range) with one exit step for each direction, splits the time of
// day into hour and minute by compare-subtract, and loads the result register
// once it is free. The year reduction, the additions, the day rollover and the
// split share the single 34-bit adder. A finished result waits in that register
// while the next request is taken. The calendar register (i_cfg_we /
// i_cfg_wdata) selects Gregorian, fixed 365-day or 30-day-month rules; write
// it only while idle. A year that leaves 0..9999 wraps modulo 16384 and raises
// year_overflow.

module calendar_date_time_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cdts_pkg::KIND_W-1:0]   i_cfg_wdata,
    cdts_in_if.sink                       i_req,
    cdts_out_if.source                    o_rsp
);

    // One-hot sequencer states
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MOD   = 11'b000_0000_0010,
        S_LOAD  = 11'b000_0000_0100,
        S_ADDH  = 11'b000_0000_1000,
        S_ADDM  = 11'b000_0001_0000,
        S_ADDMS = 11'b000_0010_0000,
        S_FWD   = 11'b000_0100_0000,
        S_BACK  = 11'b000_1000_0000,
        S_HOUR  = 11'b001_0000_0000,
        S_MIN   = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } t_state;

    t_state                               r_state, n_state;
    logic [cdts_pkg::BIT_W-1:0]           r_bit, n_bit;
    cdts_pkg::t_acc                       r_acc, n_acc;
    logic [cdts_pkg::HOUR_W-1:0]          r_hq, n_hq;
    logic [cdts_pkg::MINUTE_W-1:0]        r_mq, n_mq;
    logic [cdts_pkg::KIND_W-1:0]          r_kind;

    // Request fields held for the duration of the item
    logic signed [cdts_pkg::STEP_W-1:0]   r_step;
    logic [cdts_pkg::HOUR_W-1:0]          r_hour;
    logic [cdts_pkg::MINUTE_W-1:0]        r_min;
    logic [cdts_pkg::MILLIS_W-1:0]        r_ms;

    // Result register
    logic                                 r_o_valid;
    logic [cdts_pkg::YEAR_W-1:0]          r_o_year;
    logic [cdts_pkg::MONTH_W-1:0]         r_o_month;
    logic [cdts_pkg::DAY_W-1:0]           r_o_day;
    logic [cdts_pkg::HOUR_W-1:0]          r_o_hour;
    logic [cdts_pkg::MINUTE_W-1:0]        r_o_min;
    logic [cdts_pkg::MILLIS_W-1:0]        r_o_ms;
    logic                                 r_o_ovf;

    // Shared adder
    cdts_pkg::t_acc                       w_b;
    cdts_pkg::t_alu_op                    w_op;
    cdts_pkg::t_acc                       w_res;
    logic                                 w_neg;

    // Date unit
    cdts_pkg::t_date_ctl                  date_ctl;
    cdts_pkg::t_r400                      w_r400;
    cdts_pkg::t_year                      w_year;
    logic [cdts_pkg::MONTH_W-1:0]         w_month;
    logic [cdts_pkg::DAY_W-1:0]           w_day;

    logic                                 w_accept;
    logic                                 w_zero_step;
    logic                                 w_out_load;
    logic [cdts_pkg::PROD_W-1:0]          w_hour_ms;
    logic [cdts_pkg::PROD_W-1:0]          w_min_ms;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_zero_step = (r_step == '0);
    assign w_out_load  = (r_state == S_FIN) && (!r_o_valid || o_rsp.ready);

    // Constant products for the time-of-day fields
    assign w_hour_ms = cdts_pkg::PROD_W'(r_hour) * cdts_pkg::MS_HOUR_U;
    assign w_min_ms  = cdts_pkg::PROD_W'(r_min) * cdts_pkg::MS_MINUTE_U;

    // Pick the adder operand for the current step of the sequence
    always_comb begin
        w_b  = '0;
        w_op = cdts_pkg::ALU_ADD;
        unique case (r_state)
            S_MOD: begin
                w_b  = cdts_pkg::CYCLE_YEARS << r_bit;
                w_op = cdts_pkg::ALU_SUB;
            end
            S_ADDH: begin
                w_b = cdts_pkg::t_acc'(w_hour_ms);
            end
            S_ADDM: begin
                w_b = cdts_pkg::t_acc'(w_min_ms);
            end
            S_ADDMS: begin
                w_b = cdts_pkg::t_acc'(r_ms);
            end
            S_FWD: begin
                w_b  = cdts_pkg::MS_PER_DAY;
                w_op = cdts_pkg::ALU_SUB;
            end
            S_BACK: begin
                w_b = cdts_pkg::MS_PER_DAY;
            end
            S_HOUR: begin
                w_b  = cdts_pkg::MS_PER_HOUR << r_bit;
                w_op = cdts_pkg::ALU_SUB;
            end
            S_MIN: begin
                w_b  = cdts_pkg::MS_PER_MINUTE << r_bit;
                w_op = cdts_pkg::ALU_SUB;
            end
            S_IDLE, S_LOAD, S_FIN: begin
                w_b = '0;
            end
            default: begin
                w_b = '0;
            end
        endcase
    end

    cdts_alu u_alu (
        .i_a   (r_acc),
        .i_b   (w_b),
        .i_op  (w_op),
        .o_res (w_res),
        .o_neg (w_neg)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_bit    = r_bit;
        n_acc    = r_acc;
        n_hq     = r_hq;
        n_mq     = r_mq;
        date_ctl = '0;
        w_r400   = w_neg ? r_acc[cdts_pkg::R400_W-1:0] : w_res[cdts_pkg::R400_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Take the date, start the leap-cycle reduction on the year
                    date_ctl.load = 1'b1;
                    n_acc   = cdts_pkg::t_acc'(i_req.year_in);
                    n_bit   = cdts_pkg::BIT_W'(5);
                    n_hq    = '0;
                    n_mq    = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!w_neg) begin
                    n_acc = w_res;
                end
                if (r_bit == '0) begin
                    date_ctl.set_r400 = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_LOAD: begin
                n_acc   = cdts_pkg::t_acc'(r_step);
                n_state = S_ADDH;
            end
            S_ADDH: begin
                // A zero step normalizes the date: one day back here ...
                n_acc         = w_res;
                date_ctl.move = w_zero_step;
                date_ctl.back = 1'b1;
                n_state       = S_ADDM;
            end
            S_ADDM: begin
                // ... and one day forward here
                n_acc         = w_res;
                date_ctl.move = w_zero_step;
                n_state       = S_ADDMS;
            end
            S_ADDMS: begin
                n_acc   = w_res;
                n_state = S_FWD;
            end
            S_FWD: begin
                if (!w_neg) begin
                    n_acc         = w_res;
                    date_ctl.move = 1'b1;
                end else begin
                    n_state = S_BACK;
                end
            end
            S_BACK: begin
                if (r_acc[cdts_pkg::ACC_W-1]) begin
                    n_acc         = w_res;
                    date_ctl.move = 1'b1;
                    date_ctl.back = 1'b1;
                end else begin
                    n_bit   = cdts_pkg::BIT_W'(cdts_pkg::HOUR_W - 1);
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                if (!w_neg) begin
                    n_acc       = w_res;
                    n_hq[r_bit] = 1'b1;
                end
                if (r_bit == '0) begin
                    n_bit   = cdts_pkg::BIT_W'(cdts_pkg::MINUTE_W - 1);
                    n_state = S_MIN;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_MIN: begin
                if (!w_neg) begin
                    n_acc       = w_res;
                    n_mq[r_bit] = 1'b1;
                end
                if (r_bit == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_FIN: begin
                // Hold until the result register is free
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    cdts_date u_date (
        .i_clk   (i_clk),
        .i_ctl   (date_ctl),
        .i_kind  (r_kind),
        .i_year  (i_req.year_in),
        .i_month (i_req.month_in),
        .i_day   (i_req.day_in),
        .i_r400  (w_r400),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_kind    <= cdts_pkg::CAL_GREG;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_kind <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
        r_acc <= n_acc;
        r_hq  <= n_hq;
        r_mq  <= n_mq;
        if (w_accept) begin
            r_step <= i_req.step_millis;
            r_hour <= i_req.hour_in;
            r_min  <= i_req.minute_in;
            r_ms   <= i_req.millis_in;
        end
        if (w_out_load) begin
            r_o_year  <= w_year[cdts_pkg::YEAR_W-1:0];
            r_o_month <= w_month;
            r_o_day   <= w_day;
            r_o_hour  <= r_hq;
            r_o_min   <= r_mq;
            r_o_ms    <= r_acc[cdts_pkg::MILLIS_W-1:0];
            r_o_ovf   <= (w_year < 16'sd0) || (w_year > cdts_pkg::YEAR_MAX);
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.year_out      = r_o_year;
    assign o_rsp.month_out     = r_o_month;
    assign o_rsp.day_out       = r_o_day;
    assign o_rsp.hour_out      = r_o_hour;
    assign o_rsp.minute_out    = r_o_min;
    assign o_rsp.millis_out    = r_o_ms;
    assign o_rsp.year_overflow = r_o_ovf;

    // The day rollover must leave the total inside one day before the split
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOUR) |-> (r_acc >= 0 && r_acc < cdts_pkg::MS_PER_DAY))
        else $error("time of day out of range at hour split");

    // After the hour and minute split only milliseconds of one minute remain
    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_acc >= 0 && r_acc < cdts_pkg::MS_PER_MINUTE))
        else $error("millisecond remainder out of range");

    // Any one-day move leaves a month in 1..12
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        date_ctl.move |=> (w_month >= cdts_pkg::MONTH_JAN && w_month <= cdts_pkg::MONTH_DEC))
        else $error("month out of range after day move");

    // Finishing an item always presents a result
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_o_valid)
        else $error("finished item produced no result");

    // An accepted request starts the leap-cycle reduction
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MOD && r_bit == cdts_pkg::BIT_W'(5)))
        else $error("accepted request did not start the sequence");

endmodule
